FILE: rtl/gccw_pkg.sv
package gccw_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 256;
    localparam int NodeW = 6;
    localparam int EdgeW = $clog2(MaxEdges);
    localparam int CountW = $clog2(MaxEdges + 1);
    localparam int DepthW = $clog2(MaxNodes + 1);
    localparam int SlotW = $clog2(MaxNodes);

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_WALK = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_WALK = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [NodeW-1:0] node_a;
        logic [NodeW-1:0] node_b;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_TEST,
        ST_NEXT,
        ST_FULL
    } state_t;

    typedef struct packed {
        logic [NodeW-1:0] node;
        logic             last;
        logic             status;
    } result_t;

endpackage

FILE: rtl/gccw_front.sv
module gccw_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_mode,
    input  logic [5:0]          s_node_a,
    input  logic [5:0]          s_node_b,
    output logic                q_valid,
    input  logic                q_ready,
    output gccw_pkg::cmd_t      q_cmd
);
    import gccw_pkg::*;

    // Two-entry queue; the front tracks its own view of the edge count for full detection.
    cmd_t             buf_reg [2];
    logic [1:0]       cnt_reg;
    logic             rd_reg;
    logic [CountW-1:0] edges_reg;
    logic [CountW-1:0] edges_next;
    logic             push;
    logic             pop;
    logic             keep;
    cmd_t             c;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = buf_reg[rd_reg];
    assign pop = q_valid && q_ready;

    always_comb begin
        c.node_a = s_node_a;
        c.node_b = s_node_b;
        c.cmd = CMD_ADD;
        keep = 1'b0;
        edges_next = edges_reg;
        case (s_mode)
            MODE_ADD: begin
                keep = 1'b1;
                if (edges_reg == CountW'(MaxEdges)) begin
                    c.cmd = CMD_FULL;
                end else begin
                    edges_next = edges_reg + 1'b1;
                end
            end
            MODE_WALK: begin
                c.cmd = CMD_WALK;
                keep = 1'b1;
            end
            MODE_CLEAR: begin
                c.cmd = CMD_CLEAR;
                keep = 1'b1;
                edges_next = '0;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = s_tvalid && s_tready && keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            edges_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) edges_reg <= edges_next;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) buf_reg[rd_reg ^ (cnt_reg != 2'd0)] <= c;
    end

endmodule

FILE: rtl/gccw_back.sv
module gccw_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                walk_order,
    input  logic                q_valid,
    output logic                q_ready,
    input  gccw_pkg::cmd_t      q_cmd,
    output logic                r_valid,
    input  logic                r_ready,
    output gccw_pkg::result_t   r_data
);
    import gccw_pkg::*;

    logic [NodeW-1:0]  e1_mem [MaxEdges];
    logic [NodeW-1:0]  e2_mem [MaxEdges];
    logic [NodeW-1:0]  pn_mem [MaxNodes];
    logic [EdgeW:0]    ps_mem [MaxNodes];

    state_t            state_reg, state_next;
    logic [CountW-1:0] edges_reg;
    logic [MaxNodes-1:0] vis_reg;
    logic              dfs_reg;
    logic [DepthW-1:0] head_reg, tail_reg;
    logic [NodeW-1:0]  u_reg;
    logic [EdgeW:0]    e_reg;
    logic [NodeW-1:0]  r1_reg, r2_reg, pn_rd_reg;
    logic [EdgeW:0]    ps_rd_reg;
    logic              ov_reg;
    result_t           out_reg;
    logic [NodeW-1:0]  held_reg;

    logic              hit;
    logic [NodeW-1:0]  v;
    logic              emit;
    logic              out_free;
    logic              take;
    logic              walk_end;

    assign out_free = !ov_reg || r_ready;
    assign r_valid = ov_reg;
    assign r_data = out_reg;

    always_comb begin
        hit = 1'b0;
        v = r2_reg;
        if (r1_reg == u_reg) begin
            hit = 1'b1;
        end else if (r2_reg == u_reg) begin
            hit = 1'b1;
            v = r1_reg;
        end
    end

    assign take = hit && !vis_reg[v] && tail_reg != DepthW'(MaxNodes)
                  && ({1'b0, e_reg} < {1'b0, edges_reg});
    assign walk_end = dfs_reg ? (tail_reg == DepthW'(1)) : (head_reg == tail_reg);

    // BFS: head/tail index the queue; DFS: tail is stack depth.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.cmd)
                        CMD_WALK: state_next = ST_START;
                        CMD_FULL: state_next = ST_FULL;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FULL: if (out_free) state_next = ST_IDLE;
            ST_START: if (out_free) state_next = ST_READ;
            ST_READ: state_next = ST_TEST;
            ST_TEST: begin
                if (take) begin
                    state_next = out_free || !dfs_reg ? ST_READ : ST_TEST;
                end else begin
                    state_next = ST_READ;
                end
                if ({1'b0, e_reg} >= {1'b0, edges_reg}) state_next = ST_NEXT;
            end
            ST_NEXT: if (out_free) state_next = walk_end ? ST_IDLE : ST_READ;
            default: state_next = ST_IDLE;
        endcase
    end

    // Each member is held until the next one is known, so the final one carries last.
    always_comb begin
        emit = 1'b0;
        case (state_reg)
            ST_FULL: emit = out_free;
            ST_TEST: emit = out_free && dfs_reg && take;
            ST_NEXT: emit = out_free && (!dfs_reg || walk_end);
            default: emit = 1'b0;
        endcase
    end

    always_comb begin
        q_ready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            edges_reg <= '0;
            ov_reg <= 1'b0;
            vis_reg <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg <= emit || (ov_reg && !r_ready);
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        case (q_cmd.cmd)
                            CMD_ADD: begin
                                e1_mem[edges_reg[EdgeW-1:0]] <= q_cmd.node_a;
                                e2_mem[edges_reg[EdgeW-1:0]] <= q_cmd.node_b;
                                edges_reg <= edges_reg + 1'b1;
                            end
                            CMD_CLEAR: edges_reg <= '0;
                            CMD_WALK: begin
                                dfs_reg <= walk_order;
                                u_reg <= q_cmd.node_a;
                                vis_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FULL: if (out_free) begin
                    out_reg <= '{node: '0, last: 1'b1, status: 1'b1};
                end
                ST_START: if (out_free) begin
                    vis_reg[u_reg] <= 1'b1;
                    e_reg <= '0;
                    held_reg <= u_reg;
                    pn_mem[0] <= u_reg;
                    tail_reg <= DepthW'(1);
                    if (dfs_reg) begin
                        head_reg <= '0;
                    end else begin
                        head_reg <= DepthW'(1);
                    end
                end
                ST_READ: begin
                    r1_reg <= e1_mem[e_reg[EdgeW-1:0]];
                    r2_reg <= e2_mem[e_reg[EdgeW-1:0]];
                end
                ST_TEST: begin
                    if ({1'b0, e_reg} < {1'b0, edges_reg}) begin
                        if (take) begin
                            if (!dfs_reg) begin
                                vis_reg[v] <= 1'b1;
                                pn_mem[tail_reg[SlotW-1:0]] <= v;
                                tail_reg <= tail_reg + 1'b1;
                                e_reg <= e_reg + 1'b1;
                            end else if (out_free) begin
                                vis_reg[v] <= 1'b1;
                                out_reg <= '{node: held_reg, last: 1'b0, status: 1'b0};
                                held_reg <= v;
                                ps_mem[tail_reg[SlotW-1:0] - 1'b1] <= e_reg + 1'b1;
                                pn_mem[tail_reg[SlotW-1:0]] <= v;
                                tail_reg <= tail_reg + 1'b1;
                                u_reg <= v;
                                e_reg <= '0;
                            end
                        end else begin
                            e_reg <= e_reg + 1'b1;
                        end
                    end
                end
                ST_NEXT: if (out_free) begin
                    // Advance to next queue entry or pop the stack.
                    if (!dfs_reg) begin
                        if (walk_end) begin
                            out_reg <= '{node: held_reg, last: 1'b1, status: 1'b0};
                        end else begin
                            u_reg <= pn_rd_reg;
                            out_reg <= '{node: held_reg, last: 1'b0, status: 1'b0};
                            held_reg <= pn_rd_reg;
                            head_reg <= head_reg + 1'b1;
                            e_reg <= '0;
                        end
                    end else begin
                        if (walk_end) begin
                            out_reg <= '{node: held_reg, last: 1'b1, status: 1'b0};
                        end else begin
                            u_reg <= pn_rd_reg;
                            e_reg <= ps_rd_reg;
                            tail_reg <= tail_reg - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        pn_rd_reg <= pn_mem[dfs_reg ? SlotW'(tail_reg - 2'd2) : head_reg[SlotW-1:0]];
        ps_rd_reg <= ps_mem[SlotW'(tail_reg - 2'd2)];
    end

endmodule

FILE: rtl/graph_connected_component_walk.sv
// Connected-component walk. Edges (mode 0) load into a 256-entry store; a walk item
// (mode 1) returns the start node's component on m_tdata, last item marked by tlast;
// register walk_order (address 0) picks breadth-first (0) or depth-first preorder (1).
// A full store gives one item with status 1. A walk reads and tests every stored edge
// in turn for each component node, through states READ and TEST.
module graph_connected_component_walk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[1:0], node_a[7:2], node_b[13:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // member_node[5:0], status[6]
    output logic        m_tlast,   // last_member
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gccw_pkg::*;

    logic    walk_order_reg;
    logic    q_valid, q_ready;
    cmd_t    q_cmd;
    result_t r;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, walk_order_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) walk_order_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'd0) walk_order_reg <= pwdata[0];
    end

    gccw_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .s_mode(s_tdata[1:0]), .s_node_a(s_tdata[7:2]), .s_node_b(s_tdata[13:8]),
        .q_valid, .q_ready, .q_cmd
    );

    gccw_back u_back (
        .aclk, .aresetn, .walk_order(walk_order_reg),
        .q_valid, .q_ready, .q_cmd,
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r)
    );

    assign m_tdata = {1'b0, r.status, r.node};
    assign m_tlast = r.last;

endmodule

FILE: tb/tb_graph_connected_component_walk.sv
`timescale 1ns / 100ps

module tb_graph_connected_component_walk;
    import gccw_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int StallLimit = 200000;
    localparam int SettleCycles = 64;

    typedef struct {
        logic [NodeW-1:0] node;
        logic             last;
        logic             status;
    } member_t;

    class component_predictor;
        logic [NodeW-1:0] end_one [MaxEdges];
        logic [NodeW-1:0] end_two [MaxEdges];
        int               edge_count;
        logic             depth_first;
        member_t          expected_members[$];
        int               errors;

        function new();
            edge_count = 0;
            depth_first = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_members.size();
        endfunction

        function void push_member(int node, bit last, bit status);
            member_t m;
            m.node = node[NodeW-1:0];
            m.last = last;
            m.status = status;
            expected_members = {expected_members, m};
        endfunction

        // neighbour of u through edge e, or -1
        function int across(int u, int e);
            if (end_one[e] == u) return int'(end_two[e]);
            if (end_two[e] == u) return int'(end_one[e]);
            return -1;
        endfunction

        function void walk(int start);
            bit seen [MaxNodes];
            int nodes [MaxNodes];
            int scan [MaxNodes];
            int head, tail, depth, u, v, e, found, first_idx;
            first_idx = expected_members.size();
            foreach (seen[i]) seen[i] = 1'b0;
            seen[start] = 1'b1;
            if (!depth_first) begin
                head = 0;
                tail = 1;
                nodes[0] = start;
                while (head < tail) begin
                    u = nodes[head];
                    head++;
                    push_member(u, 1'b0, 1'b0);
                    for (e = 0; e < edge_count; e++) begin
                        v = across(u, e);
                        if (v >= 0 && !seen[v] && tail < MaxNodes) begin
                            seen[v] = 1'b1;
                            nodes[tail] = v;
                            tail++;
                        end
                    end
                end
            end else begin
                push_member(start, 1'b0, 1'b0);
                nodes[0] = start;
                scan[0] = 0;
                depth = 1;
                while (depth > 0) begin
                    u = nodes[depth-1];
                    e = scan[depth-1];
                    found = 0;
                    while (e < edge_count && !found) begin
                        v = across(u, e);
                        e++;
                        if (v >= 0 && !seen[v] && depth < MaxNodes) begin
                            scan[depth-1] = e;
                            seen[v] = 1'b1;
                            push_member(v, 1'b0, 1'b0);
                            nodes[depth] = v;
                            scan[depth] = 0;
                            depth++;
                            found = 1;
                        end
                    end
                    if (!found) depth--;
                end
            end
            expected_members[expected_members.size()-1].last = 1'b1;
            if (expected_members.size() <= first_idx) $error("empty walk");
        endfunction

        function void note_item(logic [1:0] mode, logic [NodeW-1:0] a, logic [NodeW-1:0] b);
            case (mode)
                MODE_ADD: begin
                    if (edge_count >= MaxEdges) begin
                        push_member(0, 1'b1, 1'b1);
                    end else begin
                        end_one[edge_count] = a;
                        end_two[edge_count] = b;
                        edge_count++;
                    end
                end
                MODE_WALK: walk(int'(a));
                MODE_CLEAR: edge_count = 0;
                default: ;
            endcase
        endfunction

        function void check_member(logic [NodeW-1:0] node, logic last, logic status);
            member_t exp_m;
            if (expected_members.size() == 0) begin
                $error("unexpected item: member_node %0d last %0d status %0d",
                       node, last, status);
                errors++;
                return;
            end
            exp_m = expected_members.pop_front();
            if (node !== exp_m.node) begin
                $error("member_node: expected %0d, got %0d", exp_m.node, node);
                errors++;
            end
            if (last !== exp_m.last) begin
                $error("last_member: expected %0d, got %0d", exp_m.last, last);
                errors++;
            end
            if (status !== exp_m.status) begin
                $error("status: expected %0d, got %0d", exp_m.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    component_predictor predictor;
    int send_idle_pct;
    int recv_stall_pct;
    int stall_count;

    graph_connected_component_walk u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            predictor.check_member(m_tdata[5:0], m_tlast, m_tdata[6]);
    end

    // watchdog on cycles with no item moving on either side and no APB access
    always @(posedge aclk) begin
        if (!aresetn || (m_tvalid && m_tready) || (s_tvalid && s_tready) || psel) begin
            stall_count <= 0;
        end else if (stall_count >= StallLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send_item(logic [1:0] mode, logic [5:0] a, logic [5:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = {2'b00, b, a, mode};
        do @(posedge aclk); while (!s_tready);
        predictor.note_item(mode, a, b);
    endtask

    // hold until every expected item is back and the block has settled
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        while (predictor.pending() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_walk_order(logic value);
        drain();
        @(negedge aclk);
        psel = 1;
        pwrite = 1;
        paddr = 2'd0;
        pwdata = {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, value};
        @(negedge aclk);
        penable = 1;
        do @(posedge aclk); while (!pready);
        predictor.depth_first = value;
        @(negedge aclk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic run_random(int count);
        int done, lo, hi, k;
        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 80) begin
                lo = $urandom_range(0, 56);
                hi = lo + $urandom_range(1, 7);
                if ($urandom_range(3) == 0) begin
                    send_item(MODE_CLEAR, 6'($urandom), 6'($urandom));
                    done++;
                end
                k = $urandom_range(1, 10);
                repeat (k) send_item(MODE_ADD, 6'($urandom_range(lo, hi)),
                                     6'($urandom_range(lo, hi)));
                done += k;
                k = $urandom_range(1, 3);
                repeat (k) send_item(MODE_WALK, 6'($urandom_range(lo, hi)), 6'($urandom));
                done += k;
            end else begin
                send_item(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        predictor = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        stall_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: empty graph, extremes, self loop, unused mode, clear
        send_item(MODE_WALK, 6'd0, 6'd63);
        send_item(MODE_WALK, 6'd63, 6'd0);
        send_item(MODE_ADD, 6'd0, 6'd63);
        send_item(MODE_ADD, 6'd63, 6'd5);
        send_item(MODE_ADD, 6'd5, 6'd5);
        send_item(MODE_ADD, 6'd5, 6'd0);
        send_item(MODE_ADD, 6'd10, 6'd20);
        send_item(MODE_ADD, 6'd0, 6'd42);
        send_item(MODE_WALK, 6'd0, 6'd0);
        send_item(MODE_SPARE, 6'd63, 6'd63);
        send_item(MODE_WALK, 6'd20, 6'd0);
        write_walk_order(1);
        send_item(MODE_WALK, 6'd0, 6'd63);
        send_item(MODE_WALK, 6'd5, 6'd0);
        send_item(MODE_CLEAR, 6'd63, 6'd63);
        send_item(MODE_WALK, 6'd63, 6'd0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 47 : 0;
            recv_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 24 : 0;
            for (int ord = 0; ord < 2; ord++) begin
                write_walk_order(ord[0]);
                run_random(16);
            end
        end

        // fill the store: a chain over all nodes, then random edges, then overflow
        drain();
        send_item(MODE_CLEAR, 6'd0, 6'd0);
        for (int i = 0; i < MaxNodes - 1; i++) send_item(MODE_ADD, 6'(i), 6'(i + 1));
        for (int i = MaxNodes - 1; i < MaxEdges; i++)
            send_item(MODE_ADD, 6'($urandom), 6'($urandom));
        send_item(MODE_WALK, 6'd0, 6'd0);
        write_walk_order(0);
        send_item(MODE_WALK, 6'd63, 6'd0);
        send_item(MODE_ADD, 6'd63, 6'd63);
        send_item(MODE_ADD, 6'd0, 6'd0);
        send_item(MODE_CLEAR, 6'd0, 6'd0);
        send_item(MODE_ADD, 6'd1, 6'd2);
        send_item(MODE_WALK, 6'd2, 6'd0);

        drain();
        if (predictor.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
